/* hdl/crc32cm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package crc32cm_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MIX_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED     = 1'b1;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;

  // configuration and message state seen by the update logic
  typedef struct packed {
    logic        mix_mode;
    logic        in_message;
    logic [31:0] seed;
    logic [31:0] running_value;
  } upd_ctrl_t;

  // non-reflected CRC-32, one byte MSB first, no final XOR
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {b, 24'h0};
    for (int k = 0; k < 8; k++) begin
      if (r[31]) begin
        r = {r[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[30:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/crc32cm_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface crc32cm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

/* hdl/crc32cm_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface crc32cm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] checksum;

  modport source(output valid, output checksum, input ready);
  modport sink(input valid, input checksum, output ready);
endinterface

`default_nettype wire

/* hdl/crc32cm_update.sv */
`timescale 1ns / 1ps
`default_nettype none

module crc32cm_update
  import crc32cm_pkg::*;
(
  input  wire upd_ctrl_t   ctrl,
  input  wire logic [7:0]  data_byte,
  output logic      [31:0] next_value
);

  logic [31:0] cur;
  logic [31:0] ncrc;
  logic [31:0] prod;

  // first byte of a message starts from the seed
  assign cur  = ctrl.in_message ? ctrl.running_value : ctrl.seed;
  assign ncrc = crc_byte(cur, data_byte);
  // low 32 bits of the product only
  assign prod = cur * ctrl.seed;

  always_comb begin
    if (ctrl.mix_mode) begin
      next_value = cur + prod + ncrc;
    end else begin
      next_value = ncrc;
    end
  end

endmodule

`default_nettype wire

/* hdl/crc32_checksum_with_mixing_mode.sv */
`timescale 1ns / 1ps
`default_nettype none
// Byte-wide CRC-32 (0x04C11DB7) with optional multiply-accumulate mixing.
// A last byte is registered in the input stage, then its checksum in the output
// register. Throughput: 1 byte per cycle, except while a last byte waits in the
// input stage on a full output slot; set by the running-value loop through the
// CRC XOR network and the 32x32 low-half multiply-add in crc32cm_update.
// Reset (rst, synchronous) clears the config registers, message state and all valids.

module crc32_checksum_with_mixing_mode
  import crc32cm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  crc32cm_in_if.sink                 data_in,
  crc32cm_out_if.source              result
);

  logic        mix_mode;
  logic [31:0] seed;

  logic        st_valid;
  logic [7:0]  st_byte;
  logic        st_last;

  logic [31:0] running_value;
  logic        in_message;

  logic        out_valid;
  logic [31:0] out_checksum;

  logic        st_adv;
  logic        st_fire;
  logic [31:0] next_value;
  upd_ctrl_t   ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_mode <= 1'b0;
      seed     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIX_MODE: mix_mode <= cfg_data[0];
        REG_SEED:     seed     <= cfg_data[31:0];
        default:      ;
      endcase
    end
  end

  // a last item may leave the stage only when the output slot frees up
  assign st_adv        = !st_last || !out_valid || result.ready;
  assign st_fire       = st_valid && st_adv;
  assign data_in.ready = !st_valid || st_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (data_in.ready) begin
      st_valid <= data_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data_in.valid && data_in.ready) begin
      st_byte <= data_in.data_byte;
      st_last <= data_in.last_byte;
    end
  end

  assign ctrl.mix_mode      = mix_mode;
  assign ctrl.in_message    = in_message;
  assign ctrl.seed          = seed;
  assign ctrl.running_value = running_value;

  crc32cm_update u_update (
    .ctrl       (ctrl),
    .data_byte  (st_byte),
    .next_value (next_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      running_value <= '0;
      in_message    <= 1'b0;
    end else if (st_fire) begin
      running_value <= next_value;
      in_message    <= !st_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st_fire && st_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_fire && st_last) begin
      out_checksum <= next_value;
    end
  end

  assign result.valid    = out_valid;
  assign result.checksum = out_checksum;

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import crc32cm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 800000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned RANDOM_BYTES = 1400;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  crc32cm_in_if data_in_if();
  crc32cm_out_if result_if();

  crc32_checksum_with_mixing_mode i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .data_in(data_in_if),
    .result(result_if)
  );

  // predictor state
  logic mix_cfg;
  logic [31:0] seed_cfg;
  logic [31:0] running_sum;
  logic msg_open;
  logic [31:0] expected_sums[$];

  int unsigned mismatches;
  int unsigned cycles;
  int unsigned stall_left;
  bit tx_quiet;
  bit rx_quiet;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // bit-serial form of the MSB-first CRC-32 update
  function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    logic fb;
    r = c;
    for (int k = 7; k >= 0; k--) begin
      fb = r[31] ^ b[k];
      r = {r[30:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic l);
    logic [31:0] cur;
    logic [31:0] ncrc;
    cur = msg_open ? running_sum : seed_cfg;
    ncrc = crc_next(cur, b);
    if (mix_cfg) begin
      running_sum = cur + cur * seed_cfg + ncrc;
    end else begin
      running_sum = ncrc;
    end
    if (l) begin
      expected_sums.push_back(running_sum);
      msg_open = 1'b0;
    end else begin
      msg_open = 1'b1;
    end
  endtask

  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 20);
  endfunction

  // valid stays high across back-to-back items; only a gap or drain lowers it
  task automatic send_byte(input logic [7:0] b, input logic l);
    int unsigned gap;
    gap = pick_gap(tx_quiet);
    if (gap != 0) begin
      data_in_if.valid <= 1'b0;
      data_in_if.data_byte <= 8'($urandom);
      data_in_if.last_byte <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    data_in_if.valid <= 1'b1;
    data_in_if.data_byte <= b;
    data_in_if.last_byte <= l;
    @(posedge clk);
    while (!data_in_if.ready) @(posedge clk);
    predict_byte(b, l);
  endtask

  task automatic drain();
    data_in_if.valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MIX_MODE) begin
      mix_cfg = val[0];
    end else begin
      seed_cfg = val;
    end
  endtask

  task automatic set_mode(input logic m, input logic [31:0] s);
    write_reg(REG_MIX_MODE, {31'b0, m});
    write_reg(REG_SEED, s);
  endtask

  task automatic test_plain_directed();
    logic [7:0] digits[9];
    digits = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
    set_mode(1'b0, 32'h0000_0000);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    drain();
    set_mode(1'b0, 32'hFFFF_FFFF);
    foreach (digits[i]) begin
      send_byte(digits[i], i == 8);
    end
    drain();
  endtask

  task automatic test_mix_directed();
    set_mode(1'b1, 32'hFFFF_FFFF);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    drain();
    write_reg(REG_SEED, 32'h0000_0000);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h3C, 1'b1);
    drain();
    write_reg(REG_SEED, 32'h8000_0000);
    send_byte(8'h01, 1'b1);
    drain();
  endtask

  // new mode and seed take effect on the next byte of an open message
  task automatic test_config_mid_message();
    set_mode(1'b0, 32'h0000_0001);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    drain();
    set_mode(1'b1, 32'hDEAD_BEEF);
    send_byte(8'h56, 1'b1);
    send_byte(8'h78, 1'b1);
    drain();
  endtask

  task automatic test_random_stream();
    int unsigned sent;
    int unsigned phase_sent;
    int unsigned phase;
    int unsigned len;
    int unsigned msgs;
    int unsigned r;
    logic [31:0] s;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_BYTES) begin
      drain();
      case ($urandom_range(0, 5))
        0: s = 32'h0000_0000;
        1: s = 32'hFFFF_FFFF;
        2: s = 32'h0000_0001;
        default: s = $urandom;
      endcase
      set_mode(phase < 2 ? phase[0] : 1'($urandom), s);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      phase_sent = 0;
      msgs = 0;
      while (phase_sent < 100) begin
        r = $urandom_range(0, 99);
        if (r < 15) len = 1;
        else if (r < 60) len = $urandom_range(2, 4);
        else if (r < 92) len = $urandom_range(5, 16);
        else len = $urandom_range(17, 48);
        for (int i = 0; i < len; i++) begin
          send_byte(8'($urandom), i == len - 1);
        end
        phase_sent += len;
        msgs++;
        if (phase == 3 && msgs == 5) begin
          drain();
        end
      end
      // sometimes leave a message open across the next register change
      if ($urandom_range(0, 3) == 0) begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) begin
          send_byte(8'($urandom), 1'b0);
        end
        phase_sent += len;
      end
      sent += phase_sent;
      phase++;
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      result_if.ready <= 1'b0;
    end else if (!rx_quiet && $urandom_range(0, 99) < 25) begin
      r_pick: begin
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) stall_left = $urandom_range(0, 1);
        else if (r < 95) stall_left = $urandom_range(2, 5);
        else stall_left = $urandom_range(9, 39);
      end
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (expected_sums.size() == 0) begin
        $display("%0t: unexpected checksum: expected none, actual %08h",
                 $time, result_if.checksum);
        mismatches++;
      end else begin
        want = expected_sums.pop_front();
        if (result_if.checksum !== want) begin
          $display("%0t: checksum mismatch: expected %08h, actual %08h",
                   $time, want, result_if.checksum);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    data_in_if.valid = 1'b0;
    data_in_if.data_byte = 8'h00;
    data_in_if.last_byte = 1'b0;
    result_if.ready = 1'b0;
    mix_cfg = 1'b0;
    seed_cfg = 32'h0;
    running_sum = 32'h0;
    msg_open = 1'b0;
    mismatches = 0;
    cycles = 0;
    stall_left = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_plain_directed();
    test_mix_directed();
    test_config_mid_message();
    test_random_stream();
    drain();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
